### design/odrm_pkg.sv
`default_nettype none
package odrm_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_DIV = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TURBO_DIV   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KID_DIV     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TURN    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TRIM        = 3'd4;

  // register reset values
  localparam logic [3:0] RST_DEFAULT_DIV = 4'd2;
  localparam logic [3:0] RST_TURBO_DIV   = 4'd1;
  localparam logic [3:0] RST_KID_DIV     = 4'd4;
  localparam logic [6:0] RST_MAX_TURN    = 7'd45;
  localparam logic [7:0] RST_TRIM        = 8'd0;

  // fixed command constants
  localparam logic [6:0] DRIVE_SPAN = 7'd90;
  localparam logic [7:0] NEUTRAL    = 8'd90;
  localparam logic [7:0] CMD_MIN    = 8'd5;
  localparam logic [7:0] CMD_MAX    = 8'd175;

  // axis and wheel codes
  localparam logic [1:0] AXIS_FWD  = 2'd0;
  localparam logic [1:0] AXIS_SIDE = 2'd1;
  localparam logic [1:0] AXIS_ROT  = 2'd2;
  localparam logic [1:0] WHEEL_A   = 2'd0;
  localparam logic [1:0] WHEEL_B   = 2'd1;
  localparam logic [1:0] WHEEL_C   = 2'd2;
  localparam logic [1:0] WHEEL_D   = 2'd3;

  typedef enum logic [1:0] {
    SEL_DEFAULT = 2'd0,
    SEL_TURBO   = 2'd1,
    SEL_KID     = 2'd2
  } div_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RAMP,
    ST_MODE,
    ST_WLOAD,
    ST_WSTEP,
    ST_WSTORE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [7:0] stick_fwd;
    logic [7:0] stick_side;
    logic [7:0] stick_rot;
    logic       turbo_held;
    logic       toggle_click;
    logic       stop_now;
  } in_t;

  typedef struct packed {
    logic [7:0] wheel_a;
    logic [7:0] wheel_b;
    logic [7:0] wheel_c;
    logic [7:0] wheel_d;
    logic       kid_active;
  } out_t;

  typedef struct packed {
    logic       load_in;
    logic       mul;
    logic       ramp;
    logic       mode;
    logic       wload;
    logic       wstep;
    logic       wstore;
    logic       publish;
    logic [1:0] axis;
    logic [1:0] wheel;
  } cmd_t;

  typedef struct packed {
    logic stop;
  } status_t;

endpackage
`default_nettype wire

### design/omni_drive_ramped_mixer_unit.sv
// sequence: a normal tick runs the per axis multiply and ramp steps, the mode update and
//   four 8-step shared restoring divider passes; a stop tick goes from its first multiply to finish
// throughput: one tick at a time, and finishing waits while the output holds an unaccepted beat;
//   the next beat is taken once the previous result is registered
// reset (rst_ni low, async): ramps zero, drive mode, default divisor, registers at defaults
`default_nettype none
module omni_drive_ramped_mixer_unit (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration write port
  input  wire                               cfg_we_i,
  input  wire  [odrm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [odrm_pkg::CfgDataW-1:0]     cfg_data_i,
  // stick and button beats
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  odrm_pkg::in_t                     in_data_i,
  // wheel command beats
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output odrm_pkg::out_t                    out_data_o
);

  // controller sequences: latch beat, per axis multiply then scale/ramp,
  // mode update, then per wheel load, eight divide steps and store, then publish; stop skips to publish
  odrm_pkg::cmd_t    cmd;
  odrm_pkg::status_t status;

  odrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath holds config, ramps, mode, the shared divider and the output register
  odrm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

### design/odrm_ctrl.sv
`default_nettype none
module odrm_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  odrm_pkg::status_t   status_i,
  output odrm_pkg::cmd_t      cmd_o
);

  odrm_pkg::state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [1:0] wheel_q, wheel_d;
  logic [2:0] bit_q, bit_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      odrm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = odrm_pkg::ST_MUL;
      end
      odrm_pkg::ST_MUL: begin
        state_d = status_i.stop ? odrm_pkg::ST_FINISH : odrm_pkg::ST_RAMP;
      end
      odrm_pkg::ST_RAMP: begin
        state_d = (axis_q == odrm_pkg::AXIS_ROT) ? odrm_pkg::ST_MODE : odrm_pkg::ST_MUL;
      end
      odrm_pkg::ST_MODE:  state_d = odrm_pkg::ST_WLOAD;
      odrm_pkg::ST_WLOAD: state_d = odrm_pkg::ST_WSTEP;
      odrm_pkg::ST_WSTEP: begin
        if (bit_q == 3'd7) state_d = odrm_pkg::ST_WSTORE;
      end
      odrm_pkg::ST_WSTORE: begin
        state_d = (wheel_q == odrm_pkg::WHEEL_D) ? odrm_pkg::ST_FINISH : odrm_pkg::ST_WLOAD;
      end
      odrm_pkg::ST_FINISH: begin
        if (out_free) state_d = odrm_pkg::ST_IDLE;
      end
      default: state_d = odrm_pkg::ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    axis_d  = axis_q;
    wheel_d = wheel_q;
    bit_d   = bit_q;
    case (state_q)
      odrm_pkg::ST_IDLE: begin
        axis_d  = odrm_pkg::AXIS_FWD;
        wheel_d = odrm_pkg::WHEEL_A;
      end
      odrm_pkg::ST_RAMP:   axis_d = axis_q + 2'd1;
      odrm_pkg::ST_WLOAD:  bit_d = 3'd0;
      odrm_pkg::ST_WSTEP:  bit_d = bit_q + 3'd1;
      odrm_pkg::ST_WSTORE: wheel_d = wheel_q + 2'd1;
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    cmd_o.wheel = wheel_q;
    in_ready_o  = 1'b0;
    case (state_q)
      odrm_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      odrm_pkg::ST_MUL:    cmd_o.mul = 1'b1;
      odrm_pkg::ST_RAMP:   cmd_o.ramp = 1'b1;
      odrm_pkg::ST_MODE:   cmd_o.mode = 1'b1;
      odrm_pkg::ST_WLOAD:  cmd_o.wload = 1'b1;
      odrm_pkg::ST_WSTEP:  cmd_o.wstep = 1'b1;
      odrm_pkg::ST_WSTORE: cmd_o.wstore = 1'b1;
      odrm_pkg::ST_FINISH: cmd_o.publish = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.publish | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= odrm_pkg::ST_IDLE;
      axis_q      <= '0;
      wheel_q     <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      wheel_q     <= wheel_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

### design/odrm_datapath.sv
`default_nettype none
module odrm_datapath (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [odrm_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire  [odrm_pkg::CfgDataW-1:0]        cfg_data_i,
  input  odrm_pkg::in_t                        in_data_i,
  input  odrm_pkg::cmd_t                       cmd_i,
  output odrm_pkg::status_t                    status_o,
  output odrm_pkg::out_t                       out_data_o
);

  // config registers
  logic [3:0] default_div_q, turbo_div_q, kid_div_q;
  logic [6:0] max_turn_q;
  logic [7:0] trim_q;

  // tick state
  logic signed [7:0] ramp_fwd_q, ramp_side_q, ramp_rot_q;
  logic               kid_mode_q;
  odrm_pkg::div_sel_e div_sel_q;

  // work registers
  odrm_pkg::in_t in_q;
  odrm_pkg::out_t out_q;
  logic [15:0] prod_q;
  logic [3:0]  div_q;
  logic [3:0]  rem_q;
  logic [7:0]  quo_q;
  logic        neg_q;
  logic [7:0]  wheel_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_div_q <= odrm_pkg::RST_DEFAULT_DIV;
      turbo_div_q   <= odrm_pkg::RST_TURBO_DIV;
      kid_div_q     <= odrm_pkg::RST_KID_DIV;
      max_turn_q    <= odrm_pkg::RST_MAX_TURN;
      trim_q        <= odrm_pkg::RST_TRIM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        odrm_pkg::CFG_DEFAULT_DIV: default_div_q <= cfg_data_i[3:0];
        odrm_pkg::CFG_TURBO_DIV:   turbo_div_q   <= cfg_data_i[3:0];
        odrm_pkg::CFG_KID_DIV:     kid_div_q     <= cfg_data_i[3:0];
        odrm_pkg::CFG_MAX_TURN:    max_turn_q    <= cfg_data_i[6:0];
        odrm_pkg::CFG_TRIM:        trim_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // axis select and scaling: raw * 2 * span, then / 255 by reciprocal
  logic [7:0]         raw;
  logic [6:0]         span;
  logic [15:0]        prod_d;
  logic [16:0]        recip_sum;
  logic signed [8:0]  scaled;
  logic signed [8:0]  span9;
  logic signed [8:0]  quot9;
  logic signed [7:0]  target;
  logic signed [7:0]  ramp_cur;
  logic signed [7:0]  ramp_nxt;

  always_comb begin
    case (cmd_i.axis)
      odrm_pkg::AXIS_FWD:  raw = in_q.stick_fwd;
      odrm_pkg::AXIS_SIDE: raw = in_q.stick_side;
      default:             raw = in_q.stick_rot;
    endcase
    span   = (cmd_i.axis == odrm_pkg::AXIS_ROT) ? max_turn_q : odrm_pkg::DRIVE_SPAN;
    prod_d = {8'd0, raw} * {8'd0, span, 1'b0};
  end

  always_comb begin
    recip_sum = {1'b0, prod_q} + 17'd1 + {9'd0, prod_q[15:8]};
    quot9     = recip_sum[16:8];
    span9     = {2'b00, span};
    scaled    = quot9 - span9;
    if ((scaled > -9'sd8) && (scaled < 9'sd8)) begin
      target = 8'sd0;
    end else begin
      target = scaled[7:0];
    end
    case (cmd_i.axis)
      odrm_pkg::AXIS_FWD:  ramp_cur = ramp_fwd_q;
      odrm_pkg::AXIS_SIDE: ramp_cur = ramp_side_q;
      default:             ramp_cur = ramp_rot_q;
    endcase
    if (ramp_cur < target) begin
      ramp_nxt = ramp_cur + 8'sd1;
    end else if (ramp_cur > target) begin
      ramp_nxt = ramp_cur - 8'sd1;
    end else begin
      ramp_nxt = ramp_cur;
    end
  end

  // mode and divisor select
  logic               kid_mode_d;
  odrm_pkg::div_sel_e div_sel_d;

  always_comb begin
    kid_mode_d = kid_mode_q;
    if (kid_mode_q) begin
      div_sel_d = odrm_pkg::SEL_KID;
    end else begin
      div_sel_d = in_q.turbo_held ? odrm_pkg::SEL_TURBO : odrm_pkg::SEL_DEFAULT;
    end
    if (in_q.toggle_click) begin
      kid_mode_d = ~kid_mode_q;
      div_sel_d  = kid_mode_d ? odrm_pkg::SEL_KID : odrm_pkg::SEL_DEFAULT;
    end
  end

  // wheel mix, magnitude and divisor fetch
  logic signed [9:0] fwd10, side10, rot10, mix;
  logic signed [9:0] mag10;
  logic [3:0]        div_raw;

  always_comb begin
    fwd10  = {{2{ramp_fwd_q[7]}}, ramp_fwd_q};
    side10 = {{2{ramp_side_q[7]}}, ramp_side_q};
    rot10  = {{2{ramp_rot_q[7]}}, ramp_rot_q};
    case (cmd_i.wheel)
      odrm_pkg::WHEEL_A: mix = side10 - rot10;
      odrm_pkg::WHEEL_B: mix = -fwd10 - rot10;
      odrm_pkg::WHEEL_C: mix = -side10 - rot10;
      default:           mix = fwd10 - rot10;
    endcase
    mag10 = mix[9] ? -mix : mix;
    case (div_sel_q)
      odrm_pkg::SEL_KID:   div_raw = kid_div_q;
      odrm_pkg::SEL_TURBO: div_raw = turbo_div_q;
      default:             div_raw = default_div_q;
    endcase
  end

  // restoring divide, one quotient bit per step
  logic [4:0] shifted;
  logic       fits;

  always_comb begin
    shifted = {rem_q, quo_q[7]};
    fits    = shifted >= {1'b0, div_q};
  end

  // sign, offset and clamp
  logic signed [9:0] quo10, quo_signed, trim10, cmd10;
  logic [7:0]        cmd8;

  always_comb begin
    quo10      = {2'b00, quo_q};
    quo_signed = neg_q ? -quo10 : quo10;
    trim10     = {{2{trim_q[7]}}, trim_q};
    cmd10      = quo_signed + trim10 + 10'sd90;
    if (cmd10 < 10'sd5) begin
      cmd8 = odrm_pkg::CMD_MIN;
    end else if (cmd10 > 10'sd175) begin
      cmd8 = odrm_pkg::CMD_MAX;
    end else begin
      cmd8 = cmd10[7:0];
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_fwd_q  <= '0;
      ramp_side_q <= '0;
      ramp_rot_q  <= '0;
      kid_mode_q  <= 1'b0;
      div_sel_q   <= odrm_pkg::SEL_DEFAULT;
    end else begin
      if (cmd_i.ramp) begin
        case (cmd_i.axis)
          odrm_pkg::AXIS_FWD:  ramp_fwd_q  <= ramp_nxt;
          odrm_pkg::AXIS_SIDE: ramp_side_q <= ramp_nxt;
          default:             ramp_rot_q  <= ramp_nxt;
        endcase
      end
      if (cmd_i.mode) begin
        kid_mode_q <= kid_mode_d;
        div_sel_q  <= div_sel_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_data_i;
    if (cmd_i.mul) prod_q <= prod_d;
    if (cmd_i.wload) begin
      div_q <= (div_raw == 4'd0) ? 4'd1 : div_raw;
      rem_q <= 4'd0;
      quo_q <= mag10[7:0];
      neg_q <= mix[9];
    end
    if (cmd_i.wstep) begin
      rem_q <= fits ? 4'(shifted - {1'b0, div_q}) : shifted[3:0];
      quo_q <= {quo_q[6:0], fits};
    end
    if (cmd_i.wstore) wheel_q[cmd_i.wheel] <= cmd8;
    if (cmd_i.publish) begin
      if (in_q.stop_now) begin
        out_q.wheel_a <= odrm_pkg::NEUTRAL;
        out_q.wheel_b <= odrm_pkg::NEUTRAL;
        out_q.wheel_c <= odrm_pkg::NEUTRAL;
        out_q.wheel_d <= odrm_pkg::NEUTRAL;
      end else begin
        out_q.wheel_a <= wheel_q[odrm_pkg::WHEEL_A];
        out_q.wheel_b <= wheel_q[odrm_pkg::WHEEL_B];
        out_q.wheel_c <= wheel_q[odrm_pkg::WHEEL_C];
        out_q.wheel_d <= wheel_q[odrm_pkg::WHEEL_D];
      end
      out_q.kid_active <= kid_mode_q;
    end
  end

  assign status_o.stop = in_q.stop_now;
  assign out_data_o    = out_q;

endmodule
`default_nettype wire

### bench/wheel_cmd_checker.sv
`timescale 1ns / 1ps
module wheel_cmd_checker
  import odrm_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [CfgDataW-1:0]  cfg_data_i,
  input  wire                  in_valid_i,
  input  wire                  in_ready_i,
  input  in_t                  in_data_i,
  input  wire                  out_valid_i,
  input  wire                  out_ready_i,
  input  out_t                 out_data_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  localparam int DEAD_ZONE = 8;
  localparam int RAW_FULL = 255;
  localparam int REPORT_LIMIT = 10;

  // register copies
  logic [3:0]        div_default;
  logic [3:0]        div_turbo;
  logic [3:0]        div_kid;
  logic [6:0]        turn_span;
  logic signed [7:0] trim_offset;

  // mixer state copy
  int       slew_fwd;
  int       slew_side;
  int       slew_rot;
  logic     kid_mode_q;
  div_sel_e div_sel_q;

  out_t wheel_cmd_queue[$];
  out_t expected_cmd;

  function automatic int scale_stick(logic [7:0] raw, int span);
    int v;
    v = (int'(raw) * 2 * span) / RAW_FULL - span;
    if (v > -DEAD_ZONE && v < DEAD_ZONE) v = 0;
    return v;
  endfunction

  function automatic int step_toward(int cur, int target);
    if (cur < target) return cur + 1;
    if (cur > target) return cur - 1;
    return cur;
  endfunction

  function automatic logic [7:0] wheel_command(int mix, int divisor);
    int v;
    v = mix / divisor + int'(trim_offset) + int'(NEUTRAL);
    if (v < int'(CMD_MIN)) v = int'(CMD_MIN);
    else if (v > int'(CMD_MAX)) v = int'(CMD_MAX);
    return v[7:0];
  endfunction

  // advances the state copy by one tick (a stop tick leaves it alone) and returns the wheel beat it causes
  function automatic out_t predict_tick(in_t beat);
    out_t r;
    int t_fwd;
    int t_side;
    int t_rot;
    int divisor;
    logic [3:0] div_raw;
    if (beat.stop_now) begin
      r.wheel_a = NEUTRAL;
      r.wheel_b = NEUTRAL;
      r.wheel_c = NEUTRAL;
      r.wheel_d = NEUTRAL;
      r.kid_active = kid_mode_q;
      return r;
    end
    t_fwd = scale_stick(beat.stick_fwd, int'(DRIVE_SPAN));
    t_side = scale_stick(beat.stick_side, int'(DRIVE_SPAN));
    t_rot = scale_stick(beat.stick_rot, int'(turn_span));
    if (kid_mode_q) div_sel_q = SEL_KID;
    else div_sel_q = beat.turbo_held ? SEL_TURBO : SEL_DEFAULT;
    if (beat.toggle_click) begin
      kid_mode_q = ~kid_mode_q;
      div_sel_q = kid_mode_q ? SEL_KID : SEL_DEFAULT;
    end
    slew_fwd = step_toward(slew_fwd, t_fwd);
    slew_side = step_toward(slew_side, t_side);
    slew_rot = step_toward(slew_rot, t_rot);
    case (div_sel_q)
      SEL_KID:   div_raw = div_kid;
      SEL_TURBO: div_raw = div_turbo;
      default:   div_raw = div_default;
    endcase
    divisor = (div_raw == 4'd0) ? 1 : int'(div_raw);
    r.wheel_a = wheel_command(slew_side - slew_rot, divisor);
    r.wheel_b = wheel_command(-slew_fwd - slew_rot, divisor);
    r.wheel_c = wheel_command(-slew_side - slew_rot, divisor);
    r.wheel_d = wheel_command(slew_fwd - slew_rot, divisor);
    r.kid_active = kid_mode_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_default = RST_DEFAULT_DIV;
      div_turbo = RST_TURBO_DIV;
      div_kid = RST_KID_DIV;
      turn_span = RST_MAX_TURN;
      trim_offset = RST_TRIM;
      slew_fwd = 0;
      slew_side = 0;
      slew_rot = 0;
      kid_mode_q = 1'b0;
      div_sel_q = SEL_DEFAULT;
      wheel_cmd_queue.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (wheel_cmd_queue.size() == 0) begin
          if (mismatch_count_o < REPORT_LIMIT)
            $display("%0t: wheel beat with none expected: a=%0d b=%0d c=%0d d=%0d kid=%0b",
                     $time, out_data_i.wheel_a, out_data_i.wheel_b, out_data_i.wheel_c,
                     out_data_i.wheel_d, out_data_i.kid_active);
          mismatch_count_o++;
        end else begin
          expected_cmd = wheel_cmd_queue.pop_front();
          if (out_data_i.wheel_a !== expected_cmd.wheel_a ||
              out_data_i.wheel_b !== expected_cmd.wheel_b ||
              out_data_i.wheel_c !== expected_cmd.wheel_c ||
              out_data_i.wheel_d !== expected_cmd.wheel_d ||
              out_data_i.kid_active !== expected_cmd.kid_active) begin
            if (mismatch_count_o < REPORT_LIMIT)
              $display("%0t: wheel mismatch exp a=%0d b=%0d c=%0d d=%0d kid=%0b got a=%0d b=%0d c=%0d d=%0d kid=%0b",
                       $time, expected_cmd.wheel_a, expected_cmd.wheel_b,
                       expected_cmd.wheel_c, expected_cmd.wheel_d, expected_cmd.kid_active,
                       out_data_i.wheel_a, out_data_i.wheel_b, out_data_i.wheel_c,
                       out_data_i.wheel_d, out_data_i.kid_active);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEFAULT_DIV: div_default = cfg_data_i[3:0];
          CFG_TURBO_DIV:   div_turbo = cfg_data_i[3:0];
          CFG_KID_DIV:     div_kid = cfg_data_i[3:0];
          CFG_MAX_TURN:    turn_span = cfg_data_i[6:0];
          CFG_TRIM:        trim_offset = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        wheel_cmd_queue.push_back(predict_tick(in_data_i));
      pending_o = wheel_cmd_queue.size();
    end
  end

endmodule

### bench/tb_omni_drive_ramped_mixer_unit.sv
`timescale 1ns / 1ps
module tb_omni_drive_ramped_mixer_unit;
  import odrm_pkg::*;

  // hang guard limit, with ample margin over the slowest honest run
  localparam int CYCLE_LIMIT = 600000;
  // extra wait after settling, to catch stray beats
  localparam int TAIL_CYCLES = 64;
  localparam int IDLE_PCT = 21;
  localparam int NUM_PHASES = 6;
  localparam int TICKS_PER_PHASE = 230;
  // phase with no idling on either side
  localparam int STEADY_PHASE = 3;
  // width of one input beat
  localparam int IN_BITS = $bits(in_t);
  // register indexes past the last real register
  localparam logic [CfgIdxW-1:0] FIRST_UNMAPPED_IDX = CFG_TRIM + 1'b1;
  localparam logic [CfgIdxW-1:0] LAST_IDX = {CfgIdxW{1'b1}};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                tick_valid = 1'b0;
  logic                tick_ready;
  in_t                 tick_data = '0;
  logic                cmd_valid;
  logic                cmd_ready = 1'b0;
  out_t                cmd_data;
  logic                steady = 1'b0;
  int                  mismatch_count;
  int                  pending;
  int                  cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  omni_drive_ramped_mixer_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (tick_valid),
    .in_ready_o  (tick_ready),
    .in_data_i   (tick_data),
    .out_valid_o (cmd_valid),
    .out_ready_i (cmd_ready),
    .out_data_o  (cmd_data)
  );

  // predicts every wheel beat and compares, the top only drives and judges
  wheel_cmd_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (tick_valid),
    .in_ready_i       (tick_ready),
    .in_data_i        (tick_data),
    .out_valid_i      (cmd_valid),
    .out_ready_i      (cmd_ready),
    .out_data_i       (cmd_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // wheel side backpressure, one decision per falling edge
  always @(negedge clk) begin
    cmd_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic in_t make_tick(logic [7:0] fwd, logic [7:0] side, logic [7:0] rot,
                                    logic turbo, logic toggle, logic stop);
    in_t t;
    t.stick_fwd = fwd;
    t.stick_side = side;
    t.stick_rot = rot;
    t.turbo_held = turbo;
    t.toggle_click = toggle;
    t.stop_now = stop;
    return t;
  endfunction

  // full deflection, center or anything
  function automatic logic [7:0] pick_axis();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd128;
      default: return 8'($urandom);
    endcase
  endfunction

  // valid stays up across back-to-back beats, it only drops for an idle gap
  task automatic send_tick(input in_t beat);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      tick_valid <= 1'b0;
      @(negedge clk);
    end
    tick_valid <= 1'b1;
    tick_data <= beat;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
  endtask

  // drop valid and wait until every expected wheel beat is back
  task automatic settle();
    @(negedge clk);
    tick_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
  endtask

  // register settings per phase, the block is idle whenever this runs
  task automatic apply_setting(input int phase);
    settle();
    case (phase)
      1: begin
        // fastest drive, zero kid divisor, full rotation span
        program_reg(CFG_DEFAULT_DIV, 8'd1);
        program_reg(CFG_TURBO_DIV, 8'd15);
        program_reg(CFG_KID_DIV, 8'd0);
        program_reg(CFG_MAX_TURN, 8'd90);
        program_reg(CFG_TRIM, 8'd0);
      end
      2: begin
        // slowest default, zero turbo divisor, no rotation, low trim
        program_reg(CFG_DEFAULT_DIV, 8'd15);
        program_reg(CFG_TURBO_DIV, 8'd0);
        program_reg(CFG_KID_DIV, 8'd1);
        program_reg(CFG_MAX_TURN, 8'd0);
        program_reg(CFG_TRIM, 8'(-90));
      end
      3: begin
        // rotation span past range, high trim
        program_reg(CFG_DEFAULT_DIV, 8'd3);
        program_reg(CFG_TURBO_DIV, 8'd2);
        program_reg(CFG_KID_DIV, 8'd15);
        program_reg(CFG_MAX_TURN, 8'd127);
        program_reg(CFG_TRIM, 8'd90);
      end
      4: begin
        // junk in the unused upper bits, trim at its most negative
        program_reg(CFG_DEFAULT_DIV, {4'($urandom), 4'd7});
        program_reg(CFG_TURBO_DIV, {4'($urandom), 4'd1});
        program_reg(CFG_KID_DIV, {4'($urandom), 4'd2});
        program_reg(CFG_MAX_TURN, {1'b1, 7'd91});
        program_reg(CFG_TRIM, 8'h80);
      end
      default: begin
        program_reg(CFG_DEFAULT_DIV, 8'($urandom));
        program_reg(CFG_TURBO_DIV, 8'($urandom));
        program_reg(CFG_KID_DIV, 8'($urandom));
        program_reg(CFG_MAX_TURN, 8'($urandom));
        program_reg(CFG_TRIM, 8'($urandom));
      end
    endcase
    // a write to an unmapped index must leave every register alone
    program_reg(CfgIdxW'($urandom_range(FIRST_UNMAPPED_IDX, LAST_IDX)), 8'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hang guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int phase;
    int sent;
    int run;
    int k;
    logic [7:0] fwd;
    logic [7:0] side;
    logic [7:0] rot;
    logic turbo;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed ticks on reset registers
    send_tick(make_tick(8'd128, 8'd128, 8'd128, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(8'd255, 8'd0, 8'd128, 1'b1, 1'b0, 1'b0));
    // dead zone edges: 139 and 117 scale to +/-8, 138 and 118 to +/-7
    send_tick(make_tick(8'd139, 8'd117, 8'd255, 1'b1, 1'b0, 1'b0));
    send_tick(make_tick(8'd138, 8'd118, 8'd0, 1'b0, 1'b0, 1'b0));
    // into kid mode, then turbo has no say
    send_tick(make_tick(8'd0, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0));
    send_tick(make_tick(8'd255, 8'd255, 8'd0, 1'b1, 1'b0, 1'b0));
    // stop holds everything, a toggle with it is dropped
    send_tick(make_tick(8'd128, 8'd128, 8'd128, 1'b0, 1'b0, 1'b1));
    send_tick(make_tick(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1));
    // leaving kid mode with turbo held lands on the default divisor
    send_tick(make_tick(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0));
    send_tick(make_tick(8'd255, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0));
    repeat (12) send_tick(make_tick(8'd255, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0));

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) apply_setting(phase);
      steady = (phase == STEADY_PHASE);
      sent = 0;
      while (sent < TICKS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 80) begin
          // held sticks long enough for the ramps to travel far
          fwd = pick_axis();
          side = pick_axis();
          rot = pick_axis();
          turbo = 1'($urandom);
          run = $urandom_range(1, 160);
          for (k = 0; k < run && sent < TICKS_PER_PHASE; k++) begin
            send_tick(make_tick(fwd, side, rot, turbo,
                                $urandom_range(0, 99) < 3, $urandom_range(0, 99) < 5));
            sent++;
          end
        end else begin
          // short burst of fully random ticks
          run = $urandom_range(1, 12);
          for (k = 0; k < run && sent < TICKS_PER_PHASE; k++) begin
            send_tick(in_t'(IN_BITS'($urandom)));
            sent++;
          end
        end
      end
    end
    steady = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
